>>> rtl/core/i2cws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cws_pkg
// Shared types and timing constants for the I2C register write serializer.
// ----------------------------------------------------------------------------
package i2cws_pkg;

    localparam int PHASE_W = 7;
    localparam int FRAME_W = 24;
    localparam int ADDR_W  = 7;
    localparam int DATA_W  = 9;
    localparam int DEV_W   = 8;
    localparam int SLOT_W  = 6;

    localparam logic [PHASE_W-1:0] START_TICKS = 7'd3;
    localparam logic [PHASE_W-1:0] BYTE_TICKS  = 7'd36;
    localparam logic [PHASE_W-1:0] STOP_BASE   = 7'd111;
    localparam logic [PHASE_W-1:0] LAST_TICK   = 7'd113;
    localparam logic [SLOT_W-1:0]  DATA_SLOTS  = 6'd32;

    localparam logic [DEV_W-1:0] DEV_ADDR_RESET = 8'd52;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
        logic busy;
        logic done;
    } pins_t;

    localparam pins_t PINS_IDLE = '{scl: 1'b1, sda: 1'b1, drv: 1'b1,
                                    busy: 1'b0, done: 1'b0};

endpackage

>>> rtl/core/i2cws_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cws_engine
// Transaction state and per-tick pin decode; state advances on each item.
// ----------------------------------------------------------------------------
module i2cws_engine
    import i2cws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              start_request,
    input  logic [ADDR_W-1:0] reg_addr,
    input  logic [DATA_W-1:0] reg_data,
    input  logic [DEV_W-1:0]  dev_addr,
    output pins_t             pins
);

    logic               active_reg, active_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;

    logic               starting;
    logic               run;
    logic [PHASE_W-1:0] t;
    logic [PHASE_W-1:0] u;
    logic [PHASE_W-1:0] s;
    logic [SLOT_W-1:0]  r;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         cur_byte;
    logic [2:0]         bit_idx;

    always_comb
    begin
        starting = ~active_reg & start_request;
        run      = active_reg | start_request;
        t        = starting ? '0 : phase_reg;
        frame    = starting ? {dev_addr, reg_addr, reg_data} : frame_reg;
        u        = t - START_TICKS;
        s        = t - STOP_BASE;

        // pick the byte and the slot within it
        if (u < BYTE_TICKS)
        begin
            cur_byte = frame[23:16];
            r        = u[SLOT_W-1:0];
        end
        else if (u < (BYTE_TICKS + BYTE_TICKS))
        begin
            cur_byte = frame[15:8];
            r        = SLOT_W'(u - BYTE_TICKS);
        end
        else
        begin
            cur_byte = frame[7:0];
            r        = SLOT_W'(u - BYTE_TICKS - BYTE_TICKS);
        end
        bit_idx = 3'd7 - r[4:2];

        pins      = PINS_IDLE;
        pins.busy = run;
        if (run)
        begin
            if (t < START_TICKS)
            begin
                pins.scl = (t < 7'd2);
                pins.sda = (t == '0);
            end
            else if (t < STOP_BASE)
            begin
                pins.scl = (r[1:0] == 2'd1) || (r[1:0] == 2'd2);
                if (r < DATA_SLOTS)
                begin
                    pins.sda = cur_byte[bit_idx];
                end
                else
                begin
                    // acknowledge slot: release the line
                    pins.sda = 1'b1;
                    pins.drv = 1'b0;
                end
            end
            else
            begin
                pins.scl = (s != '0);
                pins.sda = (s == 7'd2);
            end
            pins.done = (t >= LAST_TICK);
        end

        active_next = active_reg;
        phase_next  = phase_reg;
        frame_next  = frame_reg;
        if (accept && run)
        begin
            frame_next  = frame;
            active_next = ~pins.done;
            phase_next  = pins.done ? '0 : t + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= '0;
            frame_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

>>> rtl/core/i2cws_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cws_outbuf
// Result register with a skid stage so the input stall is registered.
// ----------------------------------------------------------------------------
module i2cws_outbuf
    import i2cws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pins_t push_pins,
    output logic  full,
    output logic  out_valid,
    input  logic  out_stall,
    output pins_t out_pins
);

    logic  out_valid_reg, out_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    pins_t out_pins_reg, out_pins_next;
    pins_t skid_pins_reg, skid_pins_next;
    logic  pop;

    always_comb
    begin
        pop             = out_valid_reg & ~out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_pins_next   = out_pins_reg;
        skid_pins_next  = skid_pins_reg;
        if (skid_valid_reg)
        begin
            // drain the skid entry first
            if (pop)
            begin
                out_pins_next   = skid_pins_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_pins_next  = push_pins;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_pins_next  = push_pins;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pins_reg  <= out_pins_next;
        skid_pins_reg <= skid_pins_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_pins  = out_pins_reg;

endmodule

>>> rtl/core/i2c_register_write_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_write_serializer
// Tick-driven I2C master sending one register write of 114 ticks.
// An accepted item's result is registered in the output register, or in the skid stage while held.
// Throughput: 1 item per cycle while in_stall is low; the output skid stage holds one extra result.
// Each item is one bus tick; the pin decode is one pass from the phase counter.
// Reset: idle, no result pending, device address byte 52; the output pin register itself is not reset.
// ----------------------------------------------------------------------------
module i2c_register_write_serializer
    import i2cws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              start_request,
    input  logic [ADDR_W-1:0] reg_addr,
    input  logic [DATA_W-1:0] reg_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DEV_W-1:0]  cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              scl_level,
    output logic              sda_level,
    output logic              sda_drive,
    output logic              busy_res,
    output logic              done_res
);

    logic [DEV_W-1:0] dev_addr_reg;
    logic             accept;
    logic             full;
    pins_t            pins;
    pins_t            out_pins;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dev_addr_reg <= cfg_data;
        end
    end

    i2cws_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_request (start_request),
        .reg_addr      (reg_addr),
        .reg_data      (reg_data),
        .dev_addr      (dev_addr_reg),
        .pins          (pins)
    );

    i2cws_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_pins (pins),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pins  (out_pins)
    );

    assign scl_level = out_pins.scl;
    assign sda_level = out_pins.sda;
    assign sda_drive = out_pins.drv;
    assign busy_res  = out_pins.busy;
    assign done_res  = out_pins.done;

    // skid entry only fills behind a held result
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid full with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> busy_res)
        else $error("done outside a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sda_drive) |-> (sda_level && busy_res))
        else $error("released SDA outside an acknowledge slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pins.done) |=> !(accept && pins.busy && !start_request))
        else $error("transaction continued after done");

endmodule
